FILE: src/dual_quadrature_counter_readout_unit_defines.svh
// Assertion macros for the quadrature counter readout block.
`ifndef DUAL_QUADRATURE_COUNTER_READOUT_UNIT_DEFINES_SVH
`define DUAL_QUADRATURE_COUNTER_READOUT_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DQCR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define DQCR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dqcr_pkg.sv
package dqcr_pkg;

  // Counter width of each wheel, 16 to 32.
  localparam int unsigned COUNT_WIDTH = 32;
  // Image shown to the bus reader.
  localparam int unsigned IMAGE_BYTES = 10;
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(IMAGE_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_LEFT_DIR = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_RIGHT_DIR = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_RIGHT_CNT = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_LEFT_CNT = IDX_W'(0);

  typedef enum logic [1:0] {
    CMD_PIN     = 2'd0,
    CMD_RD_ADDR = 2'd1,
    CMD_RD_DATA = 2'd2,
    CMD_WRITE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STEP_REV  = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_NONE = 2'd2
  } step_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Control for one wheel counter.
  typedef struct packed {
    logic pin_evt;
    logic clear;
    logic changed;
  } wheel_ctrl_t;

  // Read request toward the output register.
  typedef struct packed {
    logic load;
    logic addr_phase;
  } rd_req_t;

  // Classify a phase transition (A high bit, B low bit).
  function automatic step_e step_kind(logic [1:0] prev, logic [1:0] now);
    step_e s;
    unique case ({prev, now})
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: s = STEP_FWD;
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: s = STEP_REV;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

  // Sign-extend a count to the 32-bit image word.
  function automatic logic [31:0] widen(count_t v);
    return 32'($signed(v));
  endfunction

endpackage

FILE: src/dual_quadrature_counter_readout_unit.sv
// Dual quadrature counter readout.
// Input channel (in_valid_i/in_ready_o) carries one request: a pin change
// with both encoder A/B levels and changed flags, a read address phase, a
// read data byte, or a write access. Only reads produce a result, one byte
// on the output channel (out_valid_o/out_ready_i, tx_byte_o).
// A request is captured in the input register and processed from there; a
// read's byte is loaded into the output register and shows on tx_byte_o
// from it. Throughput: one request per cycle while no read waits, set by
// the input register feeding a single output register.
// Counts wrap at the counter width and are shown sign-extended to 32 bits.
// Reset clears both counts, directions, kept phases and the byte index.
// When the receiver stalls, the held byte stays on tx_byte_o; non-read
// requests keep flowing, and a read waits in the input register, which
// drops in_ready_o until the output register frees up.
`include "dual_quadrature_counter_readout_unit_defines.svh"

module dual_quadrature_counter_readout_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic       left_a_i,
  input  logic       left_b_i,
  input  logic       right_a_i,
  input  logic       right_b_i,
  input  logic       left_changed_i,
  input  logic       right_changed_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o
);
  import dqcr_pkg::*;

  logic        s1_vld_q;
  cmd_e        cmd_q;
  logic [1:0]  lph_q, rph_q;
  logic        lchg_q, rchg_q;
  logic        s1_is_rd, s1_adv, can_load;
  wheel_ctrl_t lctrl, rctrl;
  rd_req_t     rd;
  count_t      lpos, rpos;
  logic        lfwd, rfwd;
  logic [IDX_W-1:0] idx;
  logic        cnt_clear, rd_stall;

  // Advance the input register unless a read waits for the output register.
  assign s1_is_rd   = (cmd_q == CMD_RD_ADDR) || (cmd_q == CMD_RD_DATA);
  assign s1_adv     = s1_vld_q && (!s1_is_rd || can_load);
  assign in_ready_o = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  // Capture the request payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_e'(command_i);
      lph_q  <= {left_a_i, left_b_i};
      rph_q  <= {right_a_i, right_b_i};
      lchg_q <= left_changed_i;
      rchg_q <= right_changed_i;
    end
  end

  // Route the request to the counters and the readout.
  always_comb begin
    lctrl.pin_evt = s1_adv && (cmd_q == CMD_PIN);
    lctrl.clear   = s1_adv && (cmd_q == CMD_WRITE);
    lctrl.changed = lchg_q;
    rctrl.pin_evt = lctrl.pin_evt;
    rctrl.clear   = lctrl.clear;
    rctrl.changed = rchg_q;
    rd.load       = s1_adv && s1_is_rd;
    rd.addr_phase = (cmd_q == CMD_RD_ADDR);
  end

  dqcr_wheel u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lctrl),
    .phase_i    (lph_q),
    .position_o (lpos),
    .forward_o  (lfwd)
  );

  dqcr_wheel u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rctrl),
    .phase_i    (rph_q),
    .position_o (rpos),
    .forward_o  (rfwd)
  );

  dqcr_readout u_readout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd),
    .left_pos_i  (lpos),
    .right_pos_i (rpos),
    .left_fwd_i  (lfwd),
    .right_fwd_i (rfwd),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .tx_byte_o   (tx_byte_o),
    .can_load_o  (can_load),
    .index_o     (idx)
  );

  // Conditions watched by the checks below.
  assign cnt_clear = (lpos == '0) && (rpos == '0) && !lfwd && !rfwd;
  assign rd_stall  = s1_vld_q && s1_is_rd && !can_load;

  `DQCR_ASSERT_ALWAYS(a_idx_range, idx <= IDX_LAST, "byte index out of image range")
  `DQCR_ASSERT_NEXT(a_write_clears, lctrl.clear, cnt_clear, "write did not clear counters")
  `DQCR_ASSERT_NEXT(a_read_loads, rd.load, out_valid_o, "read did not load the output register")
  `DQCR_ASSERT_ALWAYS(a_read_waits, !rd_stall || !in_ready_o, "input taken while a read is stalled")

endmodule

FILE: src/dqcr_wheel.sv
module dqcr_wheel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dqcr_pkg::wheel_ctrl_t ctrl_i,
  input  logic [1:0]           phase_i,
  output dqcr_pkg::count_t     position_o,
  output logic                 forward_o
);
  import dqcr_pkg::*;

  logic [1:0] prev_q, prev_d;
  logic       fwd_q, fwd_d;
  count_t     pos_q, pos_d;
  step_e      step;

  // Decode direction on a pin change and step the count when its changed flag is set; clear on write.
  always_comb begin
    step   = step_kind(prev_q, phase_i);
    prev_d = prev_q;
    fwd_d  = fwd_q;
    pos_d  = pos_q;
    if (ctrl_i.clear) begin
      fwd_d = 1'b0;
      pos_d = '0;
    end else if (ctrl_i.pin_evt) begin
      prev_d = phase_i;
      if (step != STEP_NONE) begin
        fwd_d = (step == STEP_FWD);
      end
      if (ctrl_i.changed) begin
        pos_d = fwd_d ? pos_q + count_t'(1) : pos_q - count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      fwd_q  <= 1'b0;
      pos_q  <= '0;
    end else begin
      prev_q <= prev_d;
      fwd_q  <= fwd_d;
      pos_q  <= pos_d;
    end
  end

  assign position_o = pos_q;
  assign forward_o  = fwd_q;

endmodule

FILE: src/dqcr_readout.sv
module dqcr_readout (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dqcr_pkg::rd_req_t      rd_i,
  input  dqcr_pkg::count_t       left_pos_i,
  input  dqcr_pkg::count_t       right_pos_i,
  input  logic                   left_fwd_i,
  input  logic                   right_fwd_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             tx_byte_o,
  output logic                   can_load_o,
  output logic [dqcr_pkg::IDX_W-1:0] index_o
);
  import dqcr_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d, sel, idx_inc;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       tx_q, byte_sel;
  logic [31:0]      lw, rw;

  assign lw = widen(left_pos_i);
  assign rw = widen(right_pos_i);

  // Pick the image byte; address phase always reads byte 0, the top byte of the left count.
  always_comb begin
    sel = rd_i.addr_phase ? IDX_LEFT_CNT : idx_q;
    if (sel > IDX_LAST) begin
      sel = IDX_LEFT_CNT;
    end
    priority if (sel == IDX_RIGHT_DIR) begin
      byte_sel = {7'd0, right_fwd_i};
    end else if (sel == IDX_LEFT_DIR) begin
      byte_sel = {7'd0, left_fwd_i};
    end else if (sel >= IDX_RIGHT_CNT) begin
      byte_sel = rw[8*(2'd3 - sel[1:0]) +: 8];
    end else begin
      byte_sel = lw[8*(2'd3 - sel[1:0]) +: 8];
    end
  end

  // Advance the wrapping byte index on every read.
  always_comb begin
    idx_inc = idx_q + IDX_W'(1);
    idx_d   = idx_q;
    if (rd_i.load) begin
      idx_d = (idx_inc > IDX_LAST) ? '0 : idx_inc;
    end
  end

  assign can_load_o = !out_vld_q || out_ready_i;

  // Hold the result until the receiver takes it.
  always_comb begin
    out_vld_d = out_vld_q;
    if (rd_i.load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.load) begin
      tx_q <= byte_sel;
    end
  end

  assign out_valid_o = out_vld_q;
  assign tx_byte_o   = tx_q;
  assign index_o     = idx_q;

endmodule

FILE: dv/dual_quadrature_counter_readout_unit_test.sv
module dual_quadrature_counter_readout_unit_test;
  import dqcr_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] command_i = CMD_PIN;
  logic       left_a_i = 1'b0;
  logic       left_b_i = 1'b0;
  logic       right_a_i = 1'b0;
  logic       right_b_i = 1'b0;
  logic       left_changed_i = 1'b0;
  logic       right_changed_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] tx_byte_o;

  dual_quadrature_counter_readout_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .left_a_i       (left_a_i),
    .left_b_i       (left_b_i),
    .right_a_i      (right_a_i),
    .right_b_i      (right_b_i),
    .left_changed_i (left_changed_i),
    .right_changed_i(right_changed_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tx_byte_o      (tx_byte_o)
  );

  // Decoder state as the block should hold it.
  logic [1:0]       kept_left_phase;
  logic [1:0]       kept_right_phase;
  logic             left_dir_fwd;
  logic             right_dir_fwd;
  count_t           left_pos_exp;
  count_t           right_pos_exp;
  logic [IDX_W-1:0] read_index;

  logic [7:0] expected_bytes[$];
  int         mismatches = 0;
  int         send_idle_pct = 16;
  int         recv_idle_pct = 80;

  // Toggle the clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bound the run.
  initial begin
    #2000000;
    $display("dual_quadrature_counter_readout_unit_test: FAIL");
    $finish;
  end

  // Stall the receiver at random.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Phase one step forward or backward along the gray sequence.
  function automatic logic [1:0] phase_ahead(logic [1:0] p);
    return {p[0], ~p[1]};
  endfunction

  function automatic logic [1:0] phase_back(logic [1:0] p);
    return {~p[0], p[1]};
  endfunction

  function automatic step_e classify_step(logic [1:0] prev, logic [1:0] now);
    if (now == phase_ahead(prev)) return STEP_FWD;
    if (now == phase_back(prev)) return STEP_REV;
    return STEP_NONE;
  endfunction

  function automatic logic [7:0] image_byte(logic [IDX_W-1:0] k);
    logic signed [COUNT_WIDTH-1:0] ls;
    logic signed [COUNT_WIDTH-1:0] rs;
    logic signed [31:0]            lw;
    logic signed [31:0]            rw;
    ls = left_pos_exp;
    rs = right_pos_exp;
    lw = ls;
    rw = rs;
    if (k < IDX_RIGHT_CNT) return 8'(lw >> (8 * (3 - (k - IDX_LEFT_CNT))));
    if (k < IDX_LEFT_DIR) return 8'(rw >> (8 * (3 - (k - IDX_RIGHT_CNT))));
    if (k == IDX_LEFT_DIR) return {7'd0, left_dir_fwd};
    return {7'd0, right_dir_fwd};
  endfunction

  // Apply one accepted request to the decoder state.
  task automatic model_request(cmd_e cmd, logic [1:0] lph, logic [1:0] rph,
                               logic lc, logic rc);
    step_e            s;
    logic [IDX_W-1:0] k;
    case (cmd)
      CMD_PIN: begin
        s = classify_step(kept_left_phase, lph);
        if (s != STEP_NONE) left_dir_fwd = (s == STEP_FWD);
        s = classify_step(kept_right_phase, rph);
        if (s != STEP_NONE) right_dir_fwd = (s == STEP_FWD);
        kept_left_phase = lph;
        kept_right_phase = rph;
        if (lc) left_pos_exp = left_dir_fwd ? left_pos_exp + 1'b1 : left_pos_exp - 1'b1;
        if (rc) right_pos_exp = right_dir_fwd ? right_pos_exp + 1'b1 : right_pos_exp - 1'b1;
      end
      CMD_WRITE: begin
        left_pos_exp = '0;
        right_pos_exp = '0;
        left_dir_fwd = 1'b0;
        right_dir_fwd = 1'b0;
      end
      default: begin
        if (cmd == CMD_RD_ADDR) k = IDX_LEFT_CNT;
        else if (read_index >= IMAGE_BYTES) k = IDX_LEFT_CNT;
        else k = read_index;
        expected_bytes.push_back(image_byte(k));
        read_index = (read_index >= IDX_LAST) ? IDX_LEFT_CNT : read_index + 1'b1;
      end
    endcase
  endtask

  // Send one request; entered and left at a falling edge, valid left high.
  task automatic send_request(cmd_e cmd, logic [1:0] lph, logic [1:0] rph,
                              logic lc, logic rc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    left_a_i = lph[1];
    left_b_i = lph[0];
    right_a_i = rph[1];
    right_b_i = rph[0];
    left_changed_i = lc;
    right_changed_i = rc;
    do @(posedge clk_i); while (!in_ready_o);
    model_request(cmd, lph, rph, lc, rc);
    @(negedge clk_i);
  endtask

  // Hold off until every expected byte has come back.
  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Compare each returned byte with the oldest expectation.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h", $time, tx_byte_o);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (tx_byte_o !== want) begin
          $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                   $time, want, tx_byte_o);
          mismatches++;
        end
      end
    end
  end

  // Walk both wheels through forward, reverse, invalid and repeated steps.
  task automatic test_phase_steps();
    send_request(CMD_PIN, 2'b01, 2'b10, 1'b1, 1'b1);
    send_request(CMD_PIN, 2'b11, 2'b11, 1'b1, 1'b1);
    // invalid jump on the left, repeat on the right
    send_request(CMD_PIN, 2'b00, 2'b11, 1'b1, 1'b0);
    send_request(CMD_PIN, 2'b00, 2'b01, 1'b1, 1'b1);
    // left direction flips without a count
    send_request(CMD_PIN, 2'b10, 2'b00, 1'b0, 1'b0);
    send_request(CMD_PIN, 2'b00, 2'b10, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  // Read the whole image, through the index wrap, with pin levels that must be ignored.
  task automatic test_image_readout();
    send_request(CMD_RD_ADDR, 2'b11, 2'b11, 1'b1, 1'b1);
    repeat (10) send_request(CMD_RD_DATA, 2'b11, 2'b11, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  // Clear on write; the index and kept phases stay.
  task automatic test_write_clear();
    send_request(CMD_WRITE, 2'b11, 2'b11, 1'b1, 1'b1);
    send_request(CMD_RD_DATA, 2'b00, 2'b00, 1'b0, 1'b0);
    send_request(CMD_RD_ADDR, 2'b00, 2'b00, 1'b0, 1'b0);
    send_request(CMD_RD_DATA, 2'b01, 2'b10, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  // Pick the next phase of one wheel; bit 2 tells whether it moved.
  function automatic logic [2:0] wheel_move(logic [1:0] prev, logic trend_fwd);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return {1'b0, prev};
    if ((r < 85) == trend_fwd) return {1'b1, phase_ahead(prev)};
    return {1'b1, phase_back(prev)};
  endfunction

  // Mostly well-formed encoder motion, mixed with reads, writes and noise.
  task automatic random_traffic(int n, int s_pct, int r_pct, bit pause_midway);
    int         r;
    logic       ltrend;
    logic       rtrend;
    logic [2:0] lm;
    logic [2:0] rm;
    logic       lc;
    logic       rc;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    ltrend = $urandom_range(0, 1);
    rtrend = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_results_drained();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 99) < 3) ltrend = ~ltrend;
        if ($urandom_range(0, 99) < 3) rtrend = ~rtrend;
        lm = wheel_move(kept_left_phase, ltrend);
        rm = wheel_move(kept_right_phase, rtrend);
        lc = lm[2] ^ ($urandom_range(0, 99) < 5);
        rc = rm[2] ^ ($urandom_range(0, 99) < 5);
        send_request(CMD_PIN, lm[1:0], rm[1:0], lc, rc);
      end else if (r < 62) begin
        send_request(CMD_PIN, 2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 98) begin
        send_request(($urandom_range(0, 2) == 0) ? CMD_RD_ADDR : CMD_RD_DATA,
                     2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_request(CMD_WRITE, 2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    random_traffic(217, 16, 80, 1'b0);
    random_traffic(217, 80, 16, 1'b1);
    random_traffic(216, 0, 0, 1'b0);
  endtask

  initial begin
    kept_left_phase = 2'b00;
    kept_right_phase = 2'b00;
    left_dir_fwd = 1'b0;
    right_dir_fwd = 1'b0;
    left_pos_exp = '0;
    right_pos_exp = '0;
    read_index = IDX_LEFT_CNT;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_phase_steps();
    test_image_readout();
    test_write_clear();
    test_random_traffic();

    wait_results_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("dual_quadrature_counter_readout_unit_test: PASS");
    end else begin
      $display("dual_quadrature_counter_readout_unit_test: FAIL");
    end
    $finish;
  end

endmodule
